### hw/rtl/blist_pkg.sv
// ----------------------------------------------------------------------------
// blist_pkg
// shared types, operation and status codes for the bounded word list
// ----------------------------------------------------------------------------
package blist_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WORD_W        = 32;
   localparam int FIELD_W       = 5;

   // operation codes
   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_SEARCH = 2'd3;

   // status codes
   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;

   typedef struct packed {
      logic [1:0]        op;
      logic [WORD_W-1:0] value;
      logic [WORD_W-1:0] key;
      logic              after;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [FIELD_W-1:0] position;
      logic [FIELD_W-1:0] entries;
   } rsp_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage

### hw/rtl/blist_cell.sv
// ----------------------------------------------------------------------------
// blist_cell
// one list slot: holds a word, compares it, shifts with its neighbors
// ----------------------------------------------------------------------------
module blist_cell #(
   parameter int INDEX = 0,
   parameter int IDX_W = 4
) (
   input  logic                        clock,
   input  blist_pkg::cell_ctrl_type    ctrl,
   input  logic [IDX_W-1:0]            slot,
   input  logic [blist_pkg::WORD_W-1:0] new_word,
   input  logic [blist_pkg::WORD_W-1:0] cmp_word,
   input  logic [blist_pkg::WORD_W-1:0] left_word,
   input  logic [blist_pkg::WORD_W-1:0] right_word,
   output logic [blist_pkg::WORD_W-1:0] word,
   output logic                        match
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [blist_pkg::WORD_W-1:0] word_ff, word_in;

   always_comb begin
      word_in = word_ff;
      if (ctrl.insert) begin
         if (MY_IDX > slot) begin
            word_in = left_word;      // shift up
         end else if (MY_IDX == slot) begin
            word_in = new_word;
         end
      end else if (ctrl.remove) begin
         if (MY_IDX >= slot) begin
            word_in = right_word;     // shift down
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word  = word_ff;
   assign match = (word_ff == cmp_word);

endmodule

### hw/rtl/bounded_list_insert_remove_search_top.sv
// ----------------------------------------------------------------------------
// bounded_list_insert_remove_search_top
// ordered list of up to DEPTH words kept in a chain of cells, with append,
// relative insert, remove and search
// ----------------------------------------------------------------------------
//  channel  ports                      transfer
//  request  start, busy, req_data      accepted when start high and busy low
//  response rsp_strobe, rsp_data       valid for one cycle, cannot be stalled
//
//  append and a refused insert skip the lookup and go straight to the apply state;
//  the other operations scan the match bits of the cells one index a cycle,
//  stopping at the first matching index, or at the entry count on a miss,
//  before the apply state
//  busy is high from accept until the response strobe; a new transaction may
//  be accepted in the cycle the strobe is shown
//  synchronous reset empties the list; stored words are not cleared
// ----------------------------------------------------------------------------
module bounded_list_insert_remove_search_top #(
   parameter int DEPTH = blist_pkg::DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  blist_pkg::req_type req_data,
   output logic               rsp_strobe,
   output blist_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int W     = blist_pkg::WORD_W;
   localparam int FW    = blist_pkg::FIELD_W;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SCAN  = 3'b010,
      S_APPLY = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   blist_pkg::req_type req_ff, req_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;     // index under test
   logic [CNT_W-1:0]   pos_ff, pos_in;       // first match, or count
   logic               found_ff, found_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   blist_pkg::rsp_type rsp_ff, rsp_in;

   blist_pkg::cell_ctrl_type ctrl;
   logic [IDX_W-1:0]         slot;
   logic [W-1:0]             cmp_word;
   logic [W-1:0]             cell_word [DEPTH];
   logic [DEPTH-1:0]         cell_match;

   logic              full;
   logic [CNT_W:0]    pos_plus;
   logic [CNT_W-1:0]  ins_at;
   logic [CNT_W+FW-1:0] pos_wide, cnt_wide;

   // remove looks up the value, the rest look up the key
   assign cmp_word = (req_ff.op == blist_pkg::OP_REMOVE) ? req_ff.value : req_ff.key;
   assign full     = (count_ff == FULL_CNT);
   assign pos_plus = {1'b0, pos_ff} + (CNT_W + 1)'(1);

   // chain of cells, each taking its neighbors' words when shifting
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [W-1:0] left_w, right_w;
      if (i == 0) begin : g_first
         assign left_w = req_ff.value;
      end else begin : g_mid_l
         assign left_w = cell_word[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_w = cell_word[i];
      end else begin : g_mid_r
         assign right_w = cell_word[i+1];
      end
      blist_cell #(
         .INDEX (i),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .slot       (slot),
         .new_word   (req_ff.value),
         .cmp_word   (cmp_word),
         .left_word  (left_w),
         .right_word (right_w),
         .word       (cell_word[i]),
         .match      (cell_match[i])
      );
   end

   // placement of a relative insert
   always_comb begin
      if (req_ff.after) begin
         ins_at = (pos_plus > {1'b0, count_ff}) ? count_ff : pos_plus[CNT_W-1:0];
      end else begin
         ins_at = (pos_ff == '0) ? '0 : pos_ff - CNT_W'(1);
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      scan_in       = scan_ff;
      pos_in        = pos_ff;
      found_in      = found_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ctrl          = '0;
      slot          = '0;
      pos_wide      = '0;
      cnt_wide      = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in  = req_data;
               scan_in = '0;
               // append and a full-list insert need no lookup
               if ((req_data.op == blist_pkg::OP_APPEND) ||
                   ((req_data.op == blist_pkg::OP_INSERT) && full)) begin
                  state_in = S_APPLY;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // walk the match bits of the stored entries one per cycle
            if (scan_ff == count_ff) begin
               found_in = 1'b0;
               pos_in   = count_ff;
               state_in = S_APPLY;
            end else if (cell_match[scan_ff[IDX_W-1:0]]) begin
               found_in = 1'b1;
               pos_in   = scan_ff;
               state_in = S_APPLY;
            end else begin
               scan_in = scan_ff + CNT_W'(1);
            end
         end

         S_APPLY: begin
            rsp_in.status = blist_pkg::ST_DONE;
            pos_wide      = {{FW{1'b0}}, count_ff};
            case (req_ff.op)
               blist_pkg::OP_APPEND, blist_pkg::OP_INSERT: begin
                  if (full) begin
                     rsp_in.status = blist_pkg::ST_FULL;
                  end else begin
                     ctrl.insert = 1'b1;
                     if (req_ff.op == blist_pkg::OP_APPEND) begin
                        slot     = count_ff[IDX_W-1:0];
                        pos_wide = {{FW{1'b0}}, count_ff};
                     end else begin
                        slot     = ins_at[IDX_W-1:0];
                        pos_wide = {{FW{1'b0}}, ins_at};
                     end
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               blist_pkg::OP_REMOVE: begin
                  pos_wide = {{FW{1'b0}}, pos_ff};
                  if (found_ff) begin
                     ctrl.remove = 1'b1;
                     slot        = pos_ff[IDX_W-1:0];
                     count_in    = count_ff - CNT_W'(1);
                  end else begin
                     rsp_in.status = blist_pkg::ST_MISS;
                  end
               end
               default: begin
                  pos_wide = {{FW{1'b0}}, pos_ff};
                  if (!found_ff) begin
                     rsp_in.status = blist_pkg::ST_MISS;
                  end
               end
            endcase
            cnt_wide        = {{FW{1'b0}}, count_in};
            rsp_in.position = pos_wide[FW-1:0];
            rsp_in.entries  = cnt_wide[FW-1:0];
            rsp_strobe_in   = 1'b1;
            state_in        = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      scan_ff  <= scan_in;
      pos_ff   <= pos_in;
      found_ff <= found_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

### dv/tb_bounded_list_insert_remove_search_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_list_insert_remove_search_top
// self-checking bench for the bounded word list: a directed pass over empty,
// full and clamped-insert cases, then random operations in phases with and
// without sender gaps, checked against a cycle-free model of the list
// ----------------------------------------------------------------------------
module tb_bounded_list_insert_remove_search_top;
   import blist_pkg::*;

   localparam int LIST_DEPTH  = DEPTH_DEFAULT;
   // worst case between accepted transactions is a full scan plus a sender gap
   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 925;

   // keeps its own copy of the list and the responses still owed by the block
   class list_scoreboard;
      logic [WORD_W-1:0] words [LIST_DEPTH];
      int unsigned       count;
      rsp_type           owed_q[$];
      int unsigned       mismatches;

      function new();
         count      = 0;
         mismatches = 0;
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         mismatches++;
      endtask

      // index of the first entry equal to the word, or the count on a miss
      function int unsigned first_hit(logic [WORD_W-1:0] word);
         int unsigned i;
         for (i = 0; i < count; i++) begin
            if (words[i] == word) return i;
         end
         return count;
      endfunction

      task note_request(req_type r);
         rsp_type     e;
         int unsigned at;
         int unsigned i;
         e.status = ST_DONE;
         at = count;
         case (r.op)
            OP_APPEND: begin
               if (count >= LIST_DEPTH) begin
                  e.status = ST_FULL;
               end else begin
                  words[count] = r.value;
                  count++;
               end
            end
            OP_INSERT: begin
               if (count >= LIST_DEPTH) begin
                  e.status = ST_FULL;
               end else begin
                  at = first_hit(r.key);
                  if (r.after) at = (at + 1 > count) ? count : at + 1;
                  else at = (at == 0) ? 0 : at - 1;
                  for (i = count; i > at; i--) words[i] = words[i-1];
                  words[at] = r.value;
                  count++;
               end
            end
            OP_REMOVE: begin
               at = first_hit(r.value);
               if (at == count) begin
                  e.status = ST_MISS;
               end else begin
                  for (i = at; i + 1 < count; i++) words[i] = words[i+1];
                  count--;
               end
            end
            default: begin
               at = first_hit(r.key);
               if (at == count) e.status = ST_MISS;
            end
         endcase
         e.position = at[FIELD_W-1:0];
         e.entries  = count[FIELD_W-1:0];
         owed_q.push_back(e);
      endtask

      task check_response(rsp_type got);
         rsp_type e;
         if (owed_q.size() == 0) begin
            report_mismatch("response with no transaction outstanding");
            return;
         end
         e = owed_q.pop_front();
         if (got.status !== e.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, e.status));
         if (got.position !== e.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      got.position, e.position));
         if (got.entries !== e.entries)
            report_mismatch($sformatf("entries %0d, expected %0d", got.entries, e.entries));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   list_scoreboard board;
   int unsigned    quiet_cycles;

   bounded_list_insert_remove_search_top #(
      .DEPTH(LIST_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // monitor: the response strobed in this cycle belongs to an earlier
   // transaction, so it is checked before a transaction accepted at this edge
   // is added to the model
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) board.check_response(rsp_data);
         if (start && !busy) board.note_request(req_data);
         // watchdog on cycles where neither side moves anything
         if (rsp_strobe || (start && !busy)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   function automatic req_type make_req(logic [1:0] op, logic [WORD_W-1:0] value,
                                        logic [WORD_W-1:0] key, logic after);
      req_type r;
      r.op    = op;
      r.value = value;
      r.key   = key;
      r.after = after;
      return r;
   endfunction

   // mostly words already in the list or a small pool, so hits and duplicates
   // are common; the rest is all-zero, all-one or full-width random
   function automatic logic [WORD_W-1:0] pick_word();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (board.count != 0 && sel < 5) return board.words[$urandom_range(0, board.count - 1)];
      if (sel < 7) return WORD_W'($urandom_range(0, 7));
      if (sel == 7) return $urandom_range(0, 1) ? '1 : '0;
      return $urandom;
   endfunction

   // hold start until the block takes the transaction, then optionally idle
   task automatic send(req_type r, int unsigned gap);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender holds off until every owed response has come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.owed_q.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(int unsigned items, int unsigned idle_pct);
      req_type     r;
      int unsigned n;
      int unsigned roll;
      int unsigned gap;
      bit          growing;
      growing = 1'b1;
      for (n = 0; n < items; n++) begin
         // alternate between filling and emptying runs so full and empty
         // list states both come up often
         if (n % 40 == 0) growing = 1'($urandom_range(0, 1));
         roll = $urandom_range(0, 99);
         if (growing) begin
            r.op = (roll < 35) ? OP_APPEND : (roll < 70) ? OP_INSERT :
                   (roll < 85) ? OP_REMOVE : OP_SEARCH;
         end else begin
            r.op = (roll < 10) ? OP_APPEND : (roll < 25) ? OP_INSERT :
                   (roll < 80) ? OP_REMOVE : OP_SEARCH;
         end
         r.value = pick_word();
         r.key   = pick_word();
         r.after = 1'($urandom_range(0, 1));
         gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
         send(r, gap);
      end
   endtask

   initial begin
      int unsigned i;
      board        = new();
      quiet_cycles = 0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty list: search and remove miss, relative insert lands in slot 0
      send(make_req(OP_SEARCH, 32'h0, 32'h0, 1'b0), 0);
      send(make_req(OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 1'b0), 0);
      send(make_req(OP_INSERT, 32'hA5A5_A5A5, 32'h0, 1'b1), 0);
      // missing key before: placed at the entry count minus one, here slot 0
      send(make_req(OP_INSERT, 32'h5A5A_5A5A, 32'hDEAD_BEEF, 1'b0), 0);
      send(make_req(OP_APPEND, 32'h0, 32'hFFFF_FFFF, 1'b1), 0);
      send(make_req(OP_APPEND, 32'hFFFF_FFFF, 32'h0, 1'b0), 0);
      // key at index 0 with before: clamped to slot 0
      send(make_req(OP_INSERT, 32'h0000_0001, 32'h5A5A_5A5A, 1'b0), 0);
      // key at the last entry with after: lands at the end
      send(make_req(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1), 0);
      // missing key after: appended at the end
      send(make_req(OP_INSERT, 32'h7FFF_FFFF, 32'h1357_9BDF, 1'b1), 0);
      // fill up to the depth
      for (i = 1; i <= LIST_DEPTH - 7; i++)
         send(make_req(OP_APPEND, WORD_W'(i) * 32'h0101_0101, 32'h0, 1'b0), 0);
      // full list refuses both kinds of insert
      send(make_req(OP_APPEND, 32'h2468_ACE0, 32'h0, 1'b0), 0);
      send(make_req(OP_INSERT, 32'h2468_ACE0, 32'h0, 1'b1), 0);
      // hit at the deepest index, then a full-length miss
      send(make_req(OP_SEARCH, 32'h0, WORD_W'(LIST_DEPTH - 7) * 32'h0101_0101, 1'b0), 0);
      send(make_req(OP_SEARCH, 32'h0, 32'hCAFE_F00D, 1'b1), 0);
      // remove the last entry, the first entry, then a miss
      send(make_req(OP_REMOVE, WORD_W'(LIST_DEPTH - 7) * 32'h0101_0101, 32'h0, 1'b0), 0);
      send(make_req(OP_REMOVE, 32'h0000_0001, 32'h0, 1'b0), 0);
      send(make_req(OP_REMOVE, 32'h0BAD_0BAD, 32'h0, 1'b1), 0);
      drain();

      // random phases: back to back, heavy sender gaps, light sender gaps, back to back
      run_phase(RANDOM_ITEMS / 4, 0);
      drain();
      run_phase(RANDOM_ITEMS / 4, 57);
      drain();
      run_phase(RANDOM_ITEMS / 4, 6);
      drain();
      run_phase(RANDOM_ITEMS - 3 * (RANDOM_ITEMS / 4), 0);
      drain();

      // let any stray response show up before the verdict
      repeat (LIST_DEPTH + 8) @(posedge clock);
      if (board.owed_q.size() != 0)
         board.report_mismatch($sformatf("%0d responses never came", board.owed_q.size()));
      if (board.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
